@@ src/lrz_pkg.sv @@
// Shared constants, types and saturating helpers for the Lorenz Euler step unit.
`default_nettype none

package lrz_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 24;
    localparam int COEF_BITS  = 31;
    localparam int STEP_BITS  = 24;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [WORD_BITS-1:0] word_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_SIGMA   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RHO     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BETA    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_X = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_Y = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_Z = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [COEF_BITS-1:0] SIGMA_RST   = 31'd167772160;
    localparam logic [COEF_BITS-1:0] RHO_RST     = 31'd469762048;
    localparam logic [COEF_BITS-1:0] BETA_RST    = 31'd44739243;
    localparam logic [STEP_BITS-1:0] STEP_RST    = 24'd11744;
    localparam word_t                START_X_RST = 32'sd0;
    localparam word_t                START_Y_RST = 32'sd1677722;
    localparam word_t                START_Z_RST = 32'sd335544320;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic  clip;
        word_t val;
    } sat_res_t;

    function automatic sat_res_t sat_add(input word_t a, input word_t b);
        logic [WORD_BITS:0] s;
        sat_res_t           r;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        r.clip = (s[WORD_BITS] != s[WORD_BITS-1]);
        r.val  = r.clip ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : s[WORD_BITS-1:0];
        return r;
    endfunction

    function automatic sat_res_t sat_sub(input word_t a, input word_t b);
        logic [WORD_BITS:0] s;
        sat_res_t           r;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        r.clip = (s[WORD_BITS] != s[WORD_BITS-1]);
        r.val  = r.clip ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : s[WORD_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/lrz_fxmul.sv @@
// Shared fixed-point multiplier: registered magnitude product, then floor rounding and saturation.
`default_nettype none

module lrz_fxmul
    import lrz_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire word_t op_a,
    input  wire word_t op_b,
    output sat_res_t   res
);

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int Q_BITS    = PROD_BITS - FRAC_BITS + 1;

    logic [WORD_BITS-1:0] mag_a, mag_b;
    logic [PROD_BITS-1:0] prod_reg;
    logic                 neg_reg;
    logic [Q_BITS-1:0]    q, lim;
    logic                 round_up;

    assign mag_a = op_a[WORD_BITS-1] ? (~op_a + 1'b1) : op_a;
    assign mag_b = op_b[WORD_BITS-1] ? (~op_b + 1'b1) : op_b;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= mag_a * mag_b;
            neg_reg  <= op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
        end
    end

    // Negative results round toward minus infinity, so any dropped bit bumps the magnitude.
    always_comb begin
        round_up = neg_reg & (|prod_reg[FRAC_BITS-1:0]);
        q   = {1'b0, prod_reg[PROD_BITS-1:FRAC_BITS]} + {{(Q_BITS-1){1'b0}}, round_up};
        lim = {{(Q_BITS-WORD_BITS){1'b0}}, WORD_MAX} + {{(Q_BITS-1){1'b0}}, neg_reg};
        res.clip = (q > lim);
        if (res.clip) begin
            q = lim;
        end
        res.val = neg_reg ? (~q[WORD_BITS-1:0] + 1'b1) : q[WORD_BITS-1:0];
    end

endmodule

`default_nettype wire

@@ src/lorenz_euler_step_unit.sv @@
// Top level of the Lorenz attractor Euler integrator with its sequencer and registers.
`default_nettype none

// Each accepted item either reloads the start position (restart = 1) or advances the
// Q8.24 position by one Euler step of the Lorenz equations, and yields one result item
// with the new position and a flag that is set if any value saturated on the way.
// A step runs eight fixed-point products in sequence through one shared 32x32
// multiplier: the idle state takes the item, the run state issues the products and
// folds them in, and the done state loads the output register once it is free; a
// restart item skips the run state. s_ready is low while an item is in work.
// Configuration writes are taken at any time, but are meant to be made while idle.

module lorenz_euler_step_unit
    import lrz_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_restart,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [WORD_BITS-1:0]  m_pos_x,
    output logic signed [WORD_BITS-1:0]  m_pos_y,
    output logic signed [WORD_BITS-1:0]  m_pos_z,
    output logic                         m_clipped,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [WORD_BITS-1:0]    cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Product slots in issue order.
    localparam logic [2:0] OP_SIGMA = 3'd0;
    localparam logic [2:0] OP_RHO_X = 3'd1;
    localparam logic [2:0] OP_X_Z   = 3'd2;
    localparam logic [2:0] OP_X_Y   = 3'd3;
    localparam logic [2:0] OP_BETA  = 3'd4;
    localparam logic [2:0] OP_DX_H  = 3'd5;
    localparam logic [2:0] OP_DY_H  = 3'd6;
    localparam logic [2:0] OP_DZ_H  = 3'd7;
    localparam logic [3:0] CNT_LAST = 4'd8;

    logic [COEF_BITS-1:0] sigma_reg, rho_reg, beta_reg;
    logic [STEP_BITS-1:0] step_reg;
    word_t                start_x_reg, start_y_reg, start_z_reg;

    logic [1:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       clip_reg, clip_next;
    word_t      cur_x_reg, cur_x_next, cur_y_reg, cur_y_next, cur_z_reg, cur_z_next;
    word_t      diff_reg, diff_next, dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    word_t      tmp_reg, tmp_next;
    logic       m_valid_reg, m_valid_next;
    word_t      out_x_reg, out_y_reg, out_z_reg;
    logic       out_clip_reg;
    logic       out_load;

    word_t      op_a, op_b, step_w;
    logic       mul_en;
    sat_res_t   mul_res;
    logic [2:0] issue_op, post_op;
    sat_res_t   s1, s2;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_pos_x   = out_x_reg;
    assign m_pos_y   = out_y_reg;
    assign m_pos_z   = out_z_reg;
    assign m_clipped = out_clip_reg;

    assign step_w   = {{(WORD_BITS-STEP_BITS){1'b0}}, step_reg};
    assign issue_op = cnt_reg[2:0];
    assign post_op  = cnt_reg[2:0] - 3'd1;
    assign mul_en   = (state_reg == ST_RUN) && !cnt_reg[3];

    always_comb begin
        case (issue_op)
            OP_SIGMA: begin op_a = {1'b0, sigma_reg}; op_b = diff_reg;  end
            OP_RHO_X: begin op_a = {1'b0, rho_reg};   op_b = cur_x_reg; end
            OP_X_Z:   begin op_a = cur_x_reg;         op_b = cur_z_reg; end
            OP_X_Y:   begin op_a = cur_x_reg;         op_b = cur_y_reg; end
            OP_BETA:  begin op_a = {1'b0, beta_reg};  op_b = cur_z_reg; end
            OP_DX_H:  begin op_a = dx_reg;            op_b = step_w;    end
            OP_DY_H:  begin op_a = dy_reg;            op_b = step_w;    end
            OP_DZ_H:  begin op_a = dz_reg;            op_b = step_w;    end
            default:  begin op_a = dz_reg;            op_b = step_w;    end
        endcase
    end

    lrz_fxmul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .res  (mul_res)
    );

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        clip_next    = clip_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        cur_z_next   = cur_z_reg;
        diff_next    = diff_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        dz_next      = dz_reg;
        tmp_next     = tmp_reg;
        m_valid_next = m_valid_reg;
        s1           = '0;
        s2           = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    clip_next = 1'b0;
                    if (s_restart) begin
                        cur_x_next = start_x_reg;
                        cur_y_next = start_y_reg;
                        cur_z_next = start_z_reg;
                        state_next = ST_DONE;
                    end else begin
                        s1         = sat_sub(cur_y_reg, cur_x_reg);
                        diff_next  = s1.val;
                        clip_next  = s1.clip;
                        cnt_next   = 4'd0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                cnt_next = cnt_reg + 4'd1;
                // The product issued last cycle is folded in here.
                if (cnt_reg != 4'd0) begin
                    clip_next = clip_reg | mul_res.clip;
                    case (post_op)
                        OP_SIGMA: dx_next  = mul_res.val;
                        OP_RHO_X: tmp_next = mul_res.val;
                        OP_X_Z: begin
                            s1        = sat_sub(tmp_reg, cur_y_reg);
                            s2        = sat_sub(s1.val, mul_res.val);
                            dy_next   = s2.val;
                            clip_next = clip_reg | mul_res.clip | s1.clip | s2.clip;
                        end
                        OP_X_Y:   tmp_next = mul_res.val;
                        OP_BETA: begin
                            s1        = sat_sub(tmp_reg, mul_res.val);
                            dz_next   = s1.val;
                            clip_next = clip_reg | mul_res.clip | s1.clip;
                        end
                        OP_DX_H: begin
                            s1         = sat_add(cur_x_reg, mul_res.val);
                            cur_x_next = s1.val;
                            clip_next  = clip_reg | mul_res.clip | s1.clip;
                        end
                        OP_DY_H: begin
                            s1         = sat_add(cur_y_reg, mul_res.val);
                            cur_y_next = s1.val;
                            clip_next  = clip_reg | mul_res.clip | s1.clip;
                        end
                        OP_DZ_H: begin
                            s1         = sat_add(cur_z_reg, mul_res.val);
                            cur_z_next = s1.val;
                            clip_next  = clip_reg | mul_res.clip | s1.clip;
                        end
                        default: clip_next = clip_reg;
                    endcase
                end
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 4'd0;
            clip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            cur_x_reg   <= START_X_RST;
            cur_y_reg   <= START_Y_RST;
            cur_z_reg   <= START_Z_RST;
            sigma_reg   <= SIGMA_RST;
            rho_reg     <= RHO_RST;
            beta_reg    <= BETA_RST;
            step_reg    <= STEP_RST;
            start_x_reg <= START_X_RST;
            start_y_reg <= START_Y_RST;
            start_z_reg <= START_Z_RST;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            clip_reg    <= clip_next;
            m_valid_reg <= m_valid_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            cur_z_reg   <= cur_z_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SIGMA:   sigma_reg   <= cfg_data[COEF_BITS-1:0];
                    REG_RHO:     rho_reg     <= cfg_data[COEF_BITS-1:0];
                    REG_BETA:    beta_reg    <= cfg_data[COEF_BITS-1:0];
                    REG_STEP:    step_reg    <= cfg_data[STEP_BITS-1:0];
                    REG_START_X: start_x_reg <= cfg_data;
                    REG_START_Y: start_y_reg <= cfg_data;
                    REG_START_Z: start_z_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg <= diff_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dz_reg   <= dz_next;
        tmp_reg  <= tmp_next;
        if (out_load) begin
            out_x_reg    <= cur_x_reg;
            out_y_reg    <= cur_y_reg;
            out_z_reg    <= cur_z_reg;
            out_clip_reg <= clip_reg;
        end
    end

endmodule

`default_nettype wire
